>>> hdl/timestamp_to_time_code_core_defines.svh
// assertion macros shared by the time code core and its divider
`ifndef TIMESTAMP_TO_TIME_CODE_CORE_DEFINES_SVH
`define TIMESTAMP_TO_TIME_CODE_CORE_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define TSTC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk outside reset
`define TSTC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/tstc_pkg.sv
// types, constants and helpers for the time code core
`timescale 1ns / 1ps
`default_nettype none

package tstc_pkg;

	localparam int DW = 64;

	typedef logic [DW-1:0] word_t;
	typedef logic [7:0]    cfg_addr_t;

	localparam cfg_addr_t REG_TPS = 8'd0;
	localparam cfg_addr_t REG_TPF = 8'd1;

	localparam logic [31:0] US_PER_SEC     = 32'd1000000;
	localparam logic [31:0] HALF_US        = 32'd500000;
	localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
	localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
	localparam logic [4:0]  MAX_OFFSET_LEN = 5'd31;

	// reciprocal of the odd factor 15625 of one million, rounded up, scaled by 2^72
	localparam logic [58:0] TICK_RECIP =
		59'(((73'd1 << 72) / 73'(US_PER_SEC >> 6)) + 73'd1);

	localparam logic [31:0] TPS_RESET = 32'd90000;
	localparam logic [31:0] TPF_RESET = 32'd3000;
	localparam logic [43:0] DH_RESET  = 44'(TPS_RESET) * 44'(SECS_PER_HOUR);
	localparam logic [37:0] DM_RESET  = 38'(TPS_RESET) * 38'(SECS_PER_MIN);

	// bit length of the magnitude, clamped to 1..31
	function automatic logic [4:0] bit_len(input logic [31:0] v);
		logic [4:0] n;
		n = 5'd1;
		for (int k = 1; k < 31; k++) begin
			if (v[k]) begin
				n = 5'(k + 1);
			end
		end
		if (v[31]) begin
			n = MAX_OFFSET_LEN;
		end
		return n;
	endfunction

endpackage

`default_nettype wire

>>> hdl/tstc_ifs.sv
// handshake channel interfaces of the time code core
`timescale 1ns / 1ps
`default_nettype none

interface tstc_in_if;
	logic                valid;
	logic                ready;
	tstc_pkg::word_t     timestamp_us;
	modport source (output valid, output timestamp_us, input ready);
	modport sink (input valid, input timestamp_us, output ready);
endinterface

interface tstc_out_if;
	logic               valid;
	logic               ready;
	logic [31:0]        hours;
	logic [5:0]         minutes;
	logic [5:0]         seconds;
	logic [31:0]        frame_count;
	logic signed [31:0] tick_offset;
	logic [4:0]         offset_length;
	logic               bad_config;
	modport source (output valid, output hours, output minutes, output seconds,
		output frame_count, output tick_offset, output offset_length,
		output bad_config, input ready);
	modport sink (input valid, input hours, input minutes, input seconds,
		input frame_count, input tick_offset, input offset_length,
		input bad_config, output ready);
endinterface

interface tstc_cfg_if;
	logic                valid;
	logic                ready;
	tstc_pkg::cfg_addr_t addr;
	logic [31:0]         wdata;
	modport source (output valid, output addr, output wdata, input ready);
	modport sink (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

>>> hdl/tstc_div.sv
// pipelined restoring divider, one quotient bit per stage, with sideband
`timescale 1ns / 1ps
`default_nettype none
`include "timestamp_to_time_code_core_defines.svh"

module tstc_div #(
	parameter int SW = 1
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    adv,
	input  wire                    in_vld,
	input  wire tstc_pkg::word_t   in_num,
	input  wire tstc_pkg::word_t   divisor,
	input  wire [SW-1:0]           in_side,
	output logic                   out_vld,
	output tstc_pkg::word_t        out_quo,
	output tstc_pkg::word_t        out_rem,
	output logic [SW-1:0]          out_side
);
	import tstc_pkg::*;

	logic          vld_s  [0:DW-1];
	word_t         rem_s  [0:DW-1];
	word_t         num_s  [0:DW-1];
	word_t         quo_s  [0:DW-1];
	logic [SW-1:0] side_s [0:DW-1];

	for (genvar i = 0; i < DW; i++) begin : g_stage
		logic          cur_vld;
		word_t         cur_rem;
		word_t         cur_num;
		word_t         cur_quo;
		logic [SW-1:0] cur_side;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          fits;

		if (i == 0) begin : g_first
			assign cur_vld  = in_vld;
			assign cur_rem  = '0;
			assign cur_num  = in_num;
			assign cur_quo  = '0;
			assign cur_side = in_side;
		end else begin : g_next
			assign cur_vld  = vld_s[i-1];
			assign cur_rem  = rem_s[i-1];
			assign cur_num  = num_s[i-1];
			assign cur_quo  = quo_s[i-1];
			assign cur_side = side_s[i-1];
		end

		assign trial = {cur_rem, cur_num[DW-1]};
		assign diff  = trial - {1'b0, divisor};
		assign fits  = trial >= {1'b0, divisor};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv) begin
				vld_s[i] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i]  <= fits ? diff[DW-1:0] : trial[DW-1:0];
				num_s[i]  <= {cur_num[DW-2:0], 1'b0};
				quo_s[i]  <= {cur_quo[DW-2:0], fits};
				side_s[i] <= cur_side;
			end
		end
	end

	assign out_vld  = vld_s[DW-1];
	assign out_quo  = quo_s[DW-1];
	assign out_rem  = rem_s[DW-1];
	assign out_side = side_s[DW-1];

	`TSTC_ASSERT_IMP(a_rem_below_divisor, out_vld && divisor != '0, out_rem < divisor, "remainder not below divisor")
	`TSTC_ASSERT_NXT(a_first_stage_load, adv && in_vld, vld_s[0], "item lost at divider entry")
	`TSTC_ASSERT_NXT(a_stall_holds, !adv, $stable(out_quo) && $stable(out_vld), "divider moved while stalled")

endmodule

`default_nettype wire

>>> hdl/timestamp_to_time_code_core.sv
// timestamp to time code core: pipelined split of microsecond timestamps
// throughput: one item per cycle; four 64-stage dividers and fifteen other stages set the depth
// the whole pipeline advances together; it stalls only when the result is held
// reset: valid bits cleared, ticks_per_second 90000, ticks_per_frame 3000
`timescale 1ns / 1ps
`default_nettype none
`include "timestamp_to_time_code_core_defines.svh"

module timestamp_to_time_code_core (
	input  wire         clk,
	input  wire         arst_n,
	tstc_in_if.sink     in_ch,
	tstc_out_if.source  out_ch,
	tstc_cfg_if.sink    cfg
);
	import tstc_pkg::*;

	logic [31:0] tps_q;
	logic [31:0] tpf_q;
	logic [43:0] dh_q;
	logic [37:0] dm_q;
	logic        bad;
	logic        adv;

	// configuration, with the hour and minute divisors worked out on write
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
			tpf_q <= TPF_RESET;
			dh_q  <= DH_RESET;
			dm_q  <= DM_RESET;
		end else if (cfg.valid) begin
			case (cfg.addr)
				REG_TPS: begin
					tps_q <= cfg.wdata;
					dh_q  <= 44'(cfg.wdata) * 44'(SECS_PER_HOUR);
					dm_q  <= 38'(cfg.wdata) * 38'(SECS_PER_MIN);
				end
				REG_TPF: begin
					tpf_q <= cfg.wdata;
				end
				default: ;
			endcase
		end
	end

	assign bad = (tps_q == '0) || (tpf_q == '0);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic vld_s9, vld_s10, vld_s11, vld_s12, vld_s13, vld_s14, vld_s15;

	assign adv         = !vld_s15 || out_ch.ready;
	assign in_ch.ready = adv;

	// tick product, split into two 32x32 partial products
	logic [63:0] plo_s1, plo_s2;
	logic [31:0] tshi_s1, phi_s2;
	word_t       num_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			plo_s1  <= 64'(in_ch.timestamp_us[31:0]) * 64'(tps_q);
			tshi_s1 <= in_ch.timestamp_us[63:32];
			plo_s2  <= plo_s1;
			phi_s2  <= tshi_s1 * tps_q;
			num_s3  <= plo_s2 + {phi_s2, 32'b0} + 64'(HALF_US);
		end
	end

	// ticks: num / 1e6 = (num >> 6) / 15625, by reciprocal multiplication
	// in four 32x32 partial products, keeping bits 116:72 of the product
	logic [63:0] pll_s4;
	logic [58:0] plh_s4;
	logic [57:0] phl_s4;
	logic [52:0] phh_s4;
	logic [31:0] lo_s5;
	logic [59:0] mid_s5;
	logic [52:0] hh_s5, hh_s6;
	logic [32:0] lsum_s6;
	logic [27:0] midhi_s6;
	logic [52:0] up_sum;
	word_t       ticks_s7;

	assign up_sum = hh_s6 + 53'(midhi_s6) + 53'(lsum_s6[32]);

	always_ff @(posedge clk) begin
		if (adv) begin
			pll_s4   <= 64'(num_s3[37:6]) * 64'(TICK_RECIP[31:0]);
			plh_s4   <= 59'(num_s3[37:6]) * 59'(TICK_RECIP[58:32]);
			phl_s4   <= 58'(num_s3[63:38]) * 58'(TICK_RECIP[31:0]);
			phh_s4   <= 53'(num_s3[63:38]) * 53'(TICK_RECIP[58:32]);
			lo_s5    <= pll_s4[63:32];
			mid_s5   <= 60'(plh_s4) + 60'(phl_s4);
			hh_s5    <= phh_s4;
			lsum_s6  <= 33'(lo_s5) + 33'(mid_s5[31:0]);
			midhi_s6 <= mid_s5[59:32];
			hh_s6    <= hh_s5;
			ticks_s7 <= {19'b0, up_sum[52:8]};
		end
	end

	// hours
	logic  d2_vld;
	word_t d2_quo, d2_rem;

	tstc_div #(.SW(1)) u_div_hours (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_vld(vld_s7), .in_num(ticks_s7), .divisor(64'(dh_q)), .in_side(1'b0),
		.out_vld(d2_vld), .out_quo(d2_quo), .out_rem(d2_rem), .out_side()
	);

	// the 32-bit hour truncation folds back into the upper remainder word
	logic [31:0] hours_s8, hours_s9, cor_s8;
	word_t       rem_s8, rem_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			hours_s8 <= d2_quo[31:0];
			cor_s8   <= d2_quo[63:32] * dh_q[31:0];
			rem_s8   <= d2_rem;
			hours_s9 <= hours_s8;
			rem_s9   <= rem_s8 + {cor_s8, 32'b0};
		end
	end

	// minutes
	logic        d3_vld;
	word_t       d3_quo, d3_rem;
	logic [31:0] d3_side;

	tstc_div #(.SW(32)) u_div_minutes (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_vld(vld_s9), .in_num(rem_s9), .divisor(64'(dm_q)), .in_side(hours_s9),
		.out_vld(d3_vld), .out_quo(d3_quo), .out_rem(d3_rem), .out_side(d3_side)
	);

	logic [37:0] hm_s10, hm_s11;
	logic [31:0] cor_s10;
	word_t       rem_s10, rem_s11;

	always_ff @(posedge clk) begin
		if (adv) begin
			hm_s10  <= {d3_side, d3_quo[5:0]};
			cor_s10 <= d3_quo[63:32] * dm_q[31:0];
			rem_s10 <= d3_rem;
			hm_s11  <= hm_s10;
			rem_s11 <= rem_s10 + {cor_s10, 32'b0};
		end
	end

	// seconds
	logic        d4_vld;
	word_t       d4_quo, d4_rem;
	logic [37:0] d4_side;

	tstc_div #(.SW(38)) u_div_seconds (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_vld(vld_s11), .in_num(rem_s11), .divisor(64'(tps_q)), .in_side(hm_s11),
		.out_vld(d4_vld), .out_quo(d4_quo), .out_rem(d4_rem), .out_side(d4_side)
	);

	logic [43:0] hms_s12, hms_s13;
	logic [31:0] cor_s12;
	word_t       rem_s12, rem_s13;

	always_ff @(posedge clk) begin
		if (adv) begin
			hms_s12 <= {d4_side, d4_quo[5:0]};
			cor_s12 <= d4_quo[63:32] * tps_q;
			rem_s12 <= d4_rem;
			hms_s13 <= hms_s12;
			rem_s13 <= rem_s12 + {cor_s12, 32'b0};
		end
	end

	// frames; the offset is the low word of the frame remainder
	logic        d5_vld;
	word_t       d5_quo, d5_rem;
	logic [43:0] d5_side;

	tstc_div #(.SW(44)) u_div_frames (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_vld(vld_s13), .in_num(rem_s13), .divisor(64'(tpf_q)), .in_side(hms_s13),
		.out_vld(d5_vld), .out_quo(d5_quo), .out_rem(d5_rem), .out_side(d5_side)
	);

	logic [43:0] hms_s14;
	logic [31:0] frames_s14, off_s14, mag_s14;

	logic [31:0] hours_s15, frames_s15, off_s15;
	logic [5:0]  min_s15, sec_s15;
	logic [4:0]  len_s15;
	logic        bad_s15;

	always_ff @(posedge clk) begin
		if (adv) begin
			hms_s14    <= d5_side;
			frames_s14 <= d5_quo[31:0];
			off_s14    <= d5_rem[31:0];
			mag_s14    <= d5_rem[31] ? (32'd0 - d5_rem[31:0]) : d5_rem[31:0];
			bad_s15    <= bad;
			if (bad) begin
				hours_s15  <= '0;
				min_s15    <= '0;
				sec_s15    <= '0;
				frames_s15 <= '0;
				off_s15    <= '0;
				len_s15    <= '0;
			end else begin
				hours_s15  <= hms_s14[43:12];
				min_s15    <= hms_s14[11:6];
				sec_s15    <= hms_s14[5:0];
				frames_s15 <= frames_s14;
				off_s15    <= off_s14;
				len_s15    <= bit_len(mag_s14);
			end
		end
	end

	// valid bits of the stages outside the dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
			vld_s15 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= in_ch.valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= d2_vld;
			vld_s9  <= vld_s8;
			vld_s10 <= d3_vld;
			vld_s11 <= vld_s10;
			vld_s12 <= d4_vld;
			vld_s13 <= vld_s12;
			vld_s14 <= d5_vld;
			vld_s15 <= vld_s14;
		end
	end

	assign out_ch.valid         = vld_s15;
	assign out_ch.hours         = hours_s15;
	assign out_ch.minutes       = min_s15;
	assign out_ch.seconds       = sec_s15;
	assign out_ch.frame_count   = frames_s15;
	assign out_ch.tick_offset   = $signed(off_s15);
	assign out_ch.offset_length = len_s15;
	assign out_ch.bad_config    = bad_s15;

	`TSTC_ASSERT_IMP(a_bad_zeroes, vld_s15 && bad_s15, hours_s15 == '0 && len_s15 == '0 && off_s15 == '0, "bad config result not cleared")
	`TSTC_ASSERT_IMP(a_len_range, vld_s15 && !bad_s15, len_s15 != '0 && len_s15 <= MAX_OFFSET_LEN, "offset length out of range")
	`TSTC_ASSERT_NXT(a_stall_holds, !adv, $stable(rem_s13) && $stable(hms_s14) && $stable(vld_s14), "pipeline moved while stalled")

endmodule

`default_nettype wire

>>> tb/sv/tstc_checker.sv
// checker for the time code core: predicts every result and compares it field by field
`timescale 1ns / 1ps
`default_nettype none

module tstc_checker (
	input  wire clk,
	input  wire arst_n,
	tstc_in_if  in_ch,
	tstc_out_if out_ch,
	tstc_cfg_if cfg,
	output int  pending,
	output int  errors
);
	import tstc_pkg::*;

	typedef struct packed {
		logic [31:0] hours;
		logic [5:0]  minutes;
		logic [5:0]  seconds;
		logic [31:0] frame_count;
		logic [31:0] tick_offset;
		logic [4:0]  offset_length;
		logic        bad_config;
	} time_code_t;

	logic [31:0] tps_copy;
	logic [31:0] tpf_copy;
	time_code_t  time_code_q[$];

	function automatic time_code_t split_timestamp(input logic [63:0] ts,
			input logic [31:0] tps32, input logic [31:0] tpf32);
		time_code_t tc;
		logic [63:0] tps, tpf, ticks, rem, hrs, mins, secs, frames;
		logic [31:0] mag;
		logic [4:0]  len;
		tc = '0;
		if (tps32 == 0 || tpf32 == 0) begin
			tc.bad_config = 1'b1;
			return tc;
		end
		tps = 64'(tps32);
		tpf = 64'(tpf32);
		// product and rounding add wrap at 64 bits
		ticks = (ts * tps + 64'd500000) / 64'd1000000;
		hrs = (ticks / tps / 64'd3600) & 64'hFFFF_FFFF;
		rem = ticks - hrs * 64'd3600 * tps;
		mins = (rem / tps / 64'd60) & 64'hFFFF_FFFF;
		rem = rem - mins * 64'd60 * tps;
		secs = (rem / tps) & 64'hFFFF_FFFF;
		rem = rem - secs * tps;
		frames = (rem / tpf) & 64'hFFFF_FFFF;
		rem = rem - frames * tpf;
		tc.hours = hrs[31:0];
		tc.minutes = mins[5:0];
		tc.seconds = secs[5:0];
		tc.frame_count = frames[31:0];
		tc.tick_offset = rem[31:0];
		mag = rem[31] ? (32'd0 - rem[31:0]) : rem[31:0];
		len = 5'd1;
		for (int k = 1; k < 31; k++)
			if (mag[k])
				len = 5'(k + 1);
		if (mag[31])
			len = 5'd31;
		tc.offset_length = len;
		return tc;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		time_code_t want;
		int         mism;
		mism = 0;
		if (!arst_n) begin
			tps_copy <= TPS_RESET;
			tpf_copy <= TPF_RESET;
			time_code_q.delete();
			pending <= 0;
			errors <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.addr == REG_TPS)
					tps_copy <= cfg.wdata;
				else if (cfg.addr == REG_TPF)
					tpf_copy <= cfg.wdata;
			end
			if (in_ch.valid && in_ch.ready)
				time_code_q.push_back(split_timestamp(in_ch.timestamp_us, tps_copy, tpf_copy));
			if (out_ch.valid && out_ch.ready) begin
				if (time_code_q.size() == 0) begin
					$error("result item with no expectation waiting");
					mism = mism + 1;
				end else begin
					want = time_code_q.pop_front();
					if (out_ch.hours !== want.hours) begin
						$error("hours: expected %0d, got %0d", want.hours, out_ch.hours);
						mism = mism + 1;
					end
					if (out_ch.minutes !== want.minutes) begin
						$error("minutes: expected %0d, got %0d", want.minutes, out_ch.minutes);
						mism = mism + 1;
					end
					if (out_ch.seconds !== want.seconds) begin
						$error("seconds: expected %0d, got %0d", want.seconds, out_ch.seconds);
						mism = mism + 1;
					end
					if (out_ch.frame_count !== want.frame_count) begin
						$error("frame_count: expected %0d, got %0d", want.frame_count,
							out_ch.frame_count);
						mism = mism + 1;
					end
					if (out_ch.tick_offset !== want.tick_offset) begin
						$error("tick_offset: expected %0d, got %0d", $signed(want.tick_offset),
							out_ch.tick_offset);
						mism = mism + 1;
					end
					if (out_ch.offset_length !== want.offset_length) begin
						$error("offset_length: expected %0d, got %0d", want.offset_length,
							out_ch.offset_length);
						mism = mism + 1;
					end
					if (out_ch.bad_config !== want.bad_config) begin
						$error("bad_config: expected %0d, got %0d", want.bad_config,
							out_ch.bad_config);
						mism = mism + 1;
					end
				end
			end
			errors <= errors + mism;
			pending <= time_code_q.size();
		end
	end

endmodule

`default_nettype wire

>>> tb/sv/tb_timestamp_to_time_code_core.sv
// testbench top for the time code core: stimulus, configuration phases and verdict
`timescale 1ns / 1ps
`default_nettype none

module tb_timestamp_to_time_code_core;
	import tstc_pkg::*;

	logic clk;
	logic arst_n;
	int   pending;
	int   errors;
	int   idle_pct;
	int   stall_pct;

	tstc_in_if  in_ch();
	tstc_out_if out_ch();
	tstc_cfg_if cfg();

	timestamp_to_time_code_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	tstc_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.cfg     (cfg),
		.pending (pending),
		.errors  (errors)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic send_timestamp(input logic [63:0] ts);
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.timestamp_us <= ts;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_addr_t idx, input logic [31:0] val);
		cfg.valid <= 1'b1;
		cfg.addr <= idx;
		cfg.wdata <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] random_timestamp();
		case ($urandom_range(4))
			0: return {$urandom, $urandom};
			1: return 64'($urandom);
			2: return 64'($urandom_range(999_999));
			// around whole hours of a realistic capture clock
			3: return 64'($urandom_range(200)) * 64'd3_600_000_000 + 64'($urandom_range(2000)) - 1000;
			default: return {32'($urandom_range(15)), $urandom};
		endcase
	endfunction

	logic [63:0] directed_ts[12] = '{
		64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 64'd5, 64'd999_999, 64'd1_000_000,
		64'd3_599_999_999, 64'd3_600_000_000, 64'd59_999_999, 64'h8000_0000_0000_0000,
		64'h0000_0001_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF
	};

	logic [31:0] tps_set[8] = '{
		TPS_RESET, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd30000, 32'hFFFF_FFFF, 32'd48000, 32'd1
	};
	logic [31:0] tpf_set[8] = '{
		TPF_RESET, 32'hFFFF_FFFE, 32'd1, 32'd1001, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd7
	};

	initial begin
		arst_n = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		in_ch.valid = 1'b0;
		in_ch.timestamp_us = '0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.addr = '0;
		cfg.wdata = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < 8; p++) begin
			if (p != 0) begin
				write_reg(REG_TPS, tps_set[p]);
				write_reg(REG_TPF, tpf_set[p]);
			end
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 75; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 75; end
				default: begin idle_pct = 19; stall_pct = 19; end
			endcase
			if (p < 2)
				foreach (directed_ts[i])
					send_timestamp(directed_ts[i]);
			for (int n = 0; n < 235; n++) begin
				send_timestamp(random_timestamp());
				// hold the sender until the pipeline has emptied once per phase
				if (n == 100)
					drain();
			end
			drain();
		end

		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
